### rtl/tm16_pkg.sv
// Shared types, register offsets and helpers for the 16-bit period/compare timer.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package tm16_pkg;

   localparam int CMD_W       = 2;
   localparam int OFS_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int TMR_W       = 16;
   localparam int PRESC_W     = 10;   // prescaler wraps at 1024
   localparam int MAX_CH      = 3;
   localparam int FLAG_W      = 4;    // bit0 overflow, bit1+n compare n
   localparam int GRP_W       = 5;    // offset without its byte-select bit

   localparam int COMPARE_CHANNELS_DEF = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

   // byte registers
   localparam logic [OFS_W-1:0] OFS_CTRLA    = 6'h00;
   localparam logic [OFS_W-1:0] OFS_CTRLB    = 6'h01;
   localparam logic [OFS_W-1:0] OFS_CTRLFCLR = 6'h06;
   localparam logic [OFS_W-1:0] OFS_CTRLFSET = 6'h07;
   localparam logic [OFS_W-1:0] OFS_INTCTRL  = 6'h0A;
   localparam logic [OFS_W-1:0] OFS_INTFLAGS = 6'h0B;
   localparam logic [OFS_W-1:0] OFS_TEMP     = 6'h0F;

   // 16-bit register groups (offset >> 1)
   localparam logic [GRP_W-1:0] GRP_CNT    = 5'h10;
   localparam logic [GRP_W-1:0] GRP_PER    = 5'h13;
   localparam logic [GRP_W-1:0] GRP_CMP0   = 5'h14;
   localparam logic [GRP_W-1:0] GRP_PERBUF = 5'h1B;
   localparam logic [GRP_W-1:0] GRP_CMPBUF0 = 5'h1C;

   // one accepted word, as seen by the register block
   typedef struct packed {
      logic              valid;
      logic [CMD_W-1:0]  cmd;
      logic [OFS_W-1:0]  ofs;
      logic [BYTE_W-1:0] wdata;
   } op_type;

   // prescaler mask per clock select: divisor minus one
   function automatic logic [PRESC_W-1:0] presc_mask(input logic [2:0] sel);
      logic [PRESC_W-1:0] m;
      unique case (sel)
         3'd0:    m = 10'd0;
         3'd1:    m = 10'd1;
         3'd2:    m = 10'd3;
         3'd3:    m = 10'd7;
         3'd4:    m = 10'd15;
         3'd5:    m = 10'd63;
         3'd6:    m = 10'd255;
         default: m = 10'd1023;
      endcase
      return m;
   endfunction

   // internal flag order to INTCTRL/INTFLAGS image and back
   function automatic logic [BYTE_W-1:0] to_image(input logic [FLAG_W-1:0] v);
      return {1'b0, v[3:1], 3'b000, v[0]};
   endfunction

   function automatic logic [FLAG_W-1:0] from_image(input logic [BYTE_W-1:0] v);
      return {v[6:4], v[0]};
   endfunction

endpackage

### rtl/tm16_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on tm16_pkg.
`timescale 1ns / 1ps

interface tm16_req_if;
   logic                           valid;
   logic                           ready;
   logic [tm16_pkg::CMD_W-1:0]     cmd;
   logic [tm16_pkg::OFS_W-1:0]     reg_offset;
   logic [tm16_pkg::BYTE_W-1:0]    wdata;

   modport source (output valid, cmd, reg_offset, wdata, input ready);
   modport sink   (input valid, cmd, reg_offset, wdata, output ready);
endinterface

interface tm16_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tm16_pkg::BYTE_W-1:0]    rdata;
   logic                           irq_overflow;
   logic                           irq_compare0;
   logic                           irq_compare1;
   logic                           irq_compare2;

   modport source (output valid, rdata, irq_overflow, irq_compare0, irq_compare1,
                   irq_compare2, input ready);
   modport sink   (input valid, rdata, irq_overflow, irq_compare0, irq_compare1,
                   irq_compare2, output ready);
endinterface

### rtl/tm16_presc.sv
// Clock prescaler advanced by executed tick words; emits a count increment on the selected division.
// Depends on tm16_pkg.
`timescale 1ns / 1ps

module tm16_presc (
   input  logic       clock,
   input  logic       reset,
   input  logic       tick_evt,
   input  logic [3:0] ctrla,
   output logic       count_inc
);
   import tm16_pkg::*;

   logic [PRESC_W-1:0] presc_ff, presc_in;
   logic [PRESC_W-1:0] presc_nxt;

   assign presc_nxt = presc_ff + 10'd1;

   always_comb begin
      presc_in  = presc_ff;
      count_inc = 1'b0;
      if (tick_evt) begin
         if (!ctrla[0]) begin
            presc_in = '0;            // disabled: held at zero
         end else begin
            presc_in  = presc_nxt;
            count_inc = ((presc_nxt & presc_mask(ctrla[3:1])) == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff <= '0;
      end else begin
         presc_ff <= presc_in;
      end
   end

endmodule

### rtl/tm16_core.sv
// Timer register file: counter, period/compare with buffers, TEMP, flags.
// Depends on tm16_pkg; driven one word a cycle by the top level while its response side does not stall.
`timescale 1ns / 1ps

module tm16_core #(
   parameter int COMPARE_CHANNELS = tm16_pkg::COMPARE_CHANNELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tm16_pkg::op_type              op,
   input  logic                          count_inc,
   output logic [3:0]                    ctrla,
   output logic [tm16_pkg::BYTE_W-1:0]   rdata,
   output logic [tm16_pkg::FLAG_W-1:0]   irq
);
   import tm16_pkg::*;

   logic [TMR_W-1:0]  cnt_ff,  cnt_in;
   logic [TMR_W-1:0]  per_ff,  per_in;
   logic [TMR_W-1:0]  pbuf_ff, pbuf_in;
   logic [TMR_W-1:0]  cmp_ff  [COMPARE_CHANNELS];
   logic [TMR_W-1:0]  cmp_in  [COMPARE_CHANNELS];
   logic [TMR_W-1:0]  cbuf_ff [COMPARE_CHANNELS];
   logic [TMR_W-1:0]  cbuf_in [COMPARE_CHANNELS];
   logic [BYTE_W-1:0] temp_ff, temp_in;
   logic [3:0]        ctrla_ff, ctrla_in;
   logic [2:0]        wave_ff, wave_in;
   logic [FLAG_W-1:0] bvalid_ff, bvalid_in;
   logic [FLAG_W-1:0] ien_ff, ien_in;
   logic [FLAG_W-1:0] iflag_ff, iflag_in;

   logic [GRP_W-1:0]  grp;
   logic              wide_hit;
   logic [TMR_W-1:0]  wide_val;
   logic [TMR_W-1:0]  cnt_nxt;
   logic [TMR_W-1:0]  wide_wr;
   logic              do_tick, do_read, do_write;

   assign grp      = op.ofs[OFS_W-1:1];
   assign cnt_nxt  = cnt_ff + 16'd1;
   assign wide_wr  = {op.wdata, temp_ff};
   assign do_tick  = op.valid && (op.cmd == CMD_TICK) && count_inc;
   assign do_read  = op.valid && (op.cmd == CMD_READ);
   assign do_write = op.valid && (op.cmd == CMD_WRITE);

   // 16-bit register decode; channels beyond the configured count never hit
   always_comb begin
      wide_hit = 1'b0;
      wide_val = '0;
      if (grp == GRP_CNT) begin
         wide_hit = 1'b1;
         wide_val = cnt_ff;
      end
      if (grp == GRP_PER) begin
         wide_hit = 1'b1;
         wide_val = per_ff;
      end
      if (grp == GRP_PERBUF) begin
         wide_hit = 1'b1;
         wide_val = pbuf_ff;
      end
      for (int ch = 0; ch < COMPARE_CHANNELS; ch++) begin
         if (grp == GRP_W'(GRP_CMP0 + ch)) begin
            wide_hit = 1'b1;
            wide_val = cmp_ff[ch];
         end
         if (grp == GRP_W'(GRP_CMPBUF0 + ch)) begin
            wide_hit = 1'b1;
            wide_val = cbuf_ff[ch];
         end
      end
   end

   always_comb begin
      cnt_in    = cnt_ff;
      per_in    = per_ff;
      pbuf_in   = pbuf_ff;
      cmp_in    = cmp_ff;
      cbuf_in   = cbuf_ff;
      temp_in   = temp_ff;
      ctrla_in  = ctrla_ff;
      wave_in   = wave_ff;
      bvalid_in = bvalid_ff;
      ien_in    = ien_ff;
      iflag_in  = iflag_ff;
      rdata     = '0;

      if (do_tick) begin
         cnt_in = cnt_nxt;
         for (int ch = 0; ch < COMPARE_CHANNELS; ch++) begin
            if (cnt_nxt == cmp_ff[ch]) iflag_in[ch+1] = 1'b1;
         end
         if (cnt_nxt == per_ff) begin
            // period match: restart, load valid buffers
            cnt_in      = '0;
            iflag_in[0] = 1'b1;
            if (bvalid_ff[0]) per_in = pbuf_ff;
            for (int ch = 0; ch < COMPARE_CHANNELS; ch++) begin
               if (bvalid_ff[ch+1]) cmp_in[ch] = cbuf_ff[ch];
            end
            bvalid_in = '0;
         end
      end

      if (do_read) begin
         unique case (op.ofs)
            OFS_CTRLA:    rdata = {4'b0000, ctrla_ff};
            OFS_CTRLB:    rdata = {5'b00000, wave_ff};
            OFS_CTRLFCLR: rdata = {4'b0000, bvalid_ff};
            OFS_CTRLFSET: rdata = {4'b0000, bvalid_ff};
            OFS_INTCTRL:  rdata = to_image(ien_ff);
            OFS_INTFLAGS: rdata = to_image(iflag_ff);
            OFS_TEMP:     rdata = temp_ff;
            default: begin
               if (wide_hit) begin
                  if (op.ofs[0]) begin
                     rdata = temp_ff;
                  end else begin
                     rdata   = wide_val[BYTE_W-1:0];
                     temp_in = wide_val[TMR_W-1:BYTE_W];
                  end
               end
            end
         endcase
      end

      if (do_write) begin
         unique case (op.ofs)
            OFS_CTRLA:    ctrla_in  = op.wdata[3:0];
            OFS_CTRLB:    wave_in   = op.wdata[2:0];
            OFS_CTRLFCLR: bvalid_in = bvalid_ff & ~op.wdata[FLAG_W-1:0];
            OFS_CTRLFSET: bvalid_in = bvalid_ff | op.wdata[FLAG_W-1:0];
            OFS_INTCTRL:  ien_in    = from_image(op.wdata);
            OFS_INTFLAGS: iflag_in  = iflag_ff & ~from_image(op.wdata);
            OFS_TEMP:     temp_in   = op.wdata;
            default: begin
               if (wide_hit) begin
                  if (!op.ofs[0]) begin
                     temp_in = op.wdata;     // low byte parks in TEMP
                  end else begin
                     if (grp == GRP_CNT) cnt_in = wide_wr;
                     if (grp == GRP_PER) per_in = wide_wr;
                     if (grp == GRP_PERBUF) begin
                        pbuf_in      = wide_wr;
                        bvalid_in[0] = 1'b1;
                     end
                     for (int ch = 0; ch < COMPARE_CHANNELS; ch++) begin
                        if (grp == GRP_W'(GRP_CMP0 + ch)) cmp_in[ch] = wide_wr;
                        if (grp == GRP_W'(GRP_CMPBUF0 + ch)) begin
                           cbuf_in[ch]     = wide_wr;
                           bvalid_in[ch+1] = 1'b1;
                        end
                     end
                  end
               end
            end
         endcase
      end
   end

   assign irq   = iflag_in & ien_in;
   assign ctrla = ctrla_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         per_ff    <= '1;
         pbuf_ff   <= '1;
         for (int ch = 0; ch < COMPARE_CHANNELS; ch++) begin
            cmp_ff[ch]  <= '0;
            cbuf_ff[ch] <= '0;
         end
         temp_ff   <= '0;
         ctrla_ff  <= '0;
         wave_ff   <= '0;
         bvalid_ff <= '0;
         ien_ff    <= '0;
         iflag_ff  <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         per_ff    <= per_in;
         pbuf_ff   <= pbuf_in;
         cmp_ff    <= cmp_in;
         cbuf_ff   <= cbuf_in;
         temp_ff   <= temp_in;
         ctrla_ff  <= ctrla_in;
         wave_ff   <= wave_in;
         bvalid_ff <= bvalid_in;
         ien_ff    <= ien_in;
         iflag_ff  <= iflag_in;
      end
   end

endmodule

### rtl/timer16_period_compare_regs.sv
// 16-bit timer with period and buffered compare channels, bytewise bus access.
// A request passes the input word register, then the response register, and
// executes as it moves from one to the other. The block takes one word per
// cycle while the response side does not stall.
// Reset (synchronous): counter and compares 0, period and period buffer
// 0xFFFF, timer disabled, all flags/enables/valid bits clear, pipe empty.
`timescale 1ns / 1ps

module timer16_period_compare_regs #(
   parameter int COMPARE_CHANNELS = tm16_pkg::COMPARE_CHANNELS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tm16_req_if.sink  req_ch,
   tm16_rsp_if.source rsp_ch
);
   import tm16_pkg::*;

   // input word register: holds one word while the response side stalls
   logic               in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]   in_cmd_ff;
   logic [OFS_W-1:0]   in_ofs_ff;
   logic [BYTE_W-1:0]  in_wdata_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_rdata_ff;
   logic [FLAG_W-1:0]  rsp_irq_ff;

   logic               req_take;   // word accepted on the request side
   logic               advance;    // word in the input register is executed
   op_type             op;
   logic               count_inc;
   logic [3:0]         ctrla;
   logic [BYTE_W-1:0]  rdata;
   logic [FLAG_W-1:0]  irq;

   // a word executes (and updates the timer state) when it moves to the
   // response register; state changes and the response are thus in word order
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   assign op.valid = advance;
   assign op.cmd   = in_cmd_ff;
   assign op.ofs   = in_ofs_ff;
   assign op.wdata = in_wdata_ff;

   // prescaler only sees executed clock-tick words
   tm16_presc u_presc (
      .clock     (clock),
      .reset     (reset),
      .tick_evt  (advance && (in_cmd_ff == CMD_TICK)),
      .ctrla     (ctrla),
      .count_inc (count_inc)
   );

   tm16_core #(
      .COMPARE_CHANNELS (COMPARE_CHANNELS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .count_inc (count_inc),
      .ctrla     (ctrla),
      .rdata     (rdata),
      .irq       (irq)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_ch.cmd;
         in_ofs_ff   <= req_ch.reg_offset;
         in_wdata_ff <= req_ch.wdata;
      end
      if (advance) begin
         rsp_rdata_ff <= rdata;
         rsp_irq_ff   <= irq;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.rdata        = rsp_rdata_ff;
   assign rsp_ch.irq_overflow = rsp_irq_ff[0];
   assign rsp_ch.irq_compare0 = rsp_irq_ff[1];
   assign rsp_ch.irq_compare1 = rsp_irq_ff[2];
   assign rsp_ch.irq_compare2 = rsp_irq_ff[3];

   // a stalled input word is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_take && in_valid_ff && !advance))
      else $error("request taken over a held word");

   // an executed word always lands in the response register
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("executed word lost");

   // a held word stays until it executes
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held word dropped");

   // pipe comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!in_valid_ff && !rsp_valid_ff))
      else $error("pipe not empty after reset");

endmodule

### sim/timer16_period_compare_regs_tb.sv
// Self-checking bench for the 16-bit period/compare timer: drives tick and bus words,
// predicts every response word in a shadow timer and checks it as it leaves the block.
// Depends on rtl/tm16_pkg.sv, rtl/tm16_if.sv and rtl/timer16_period_compare_regs.sv.
`timescale 1ns / 1ps

module timer16_period_compare_regs_tb;
   import tm16_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int DRAIN_CYCLES = 10;   // well past the two-stage pipe

   // wide register slots in the shadow timer
   localparam int SLOT_NONE   = -1;
   localparam int SLOT_CNT    = 0;
   localparam int SLOT_PER    = 1;
   localparam int SLOT_CMP    = 2;    // 2..4
   localparam int SLOT_PERBUF = 5;
   localparam int SLOT_CMPBUF = 6;    // 6..8; buffer slots map onto valid bits
   localparam int NUM_SLOTS   = 9;

   localparam logic [GRP_W-1:0] GRP_SPARE = GRP_CMPBUF0 + 5'd3;   // channel that is not there

   localparam int TICK_DIVISOR [8] = '{1, 2, 4, 8, 16, 64, 256, 1024};

   typedef struct packed {
      logic [BYTE_W-1:0] rdata;
      logic              irq_overflow;
      logic              irq_compare0;
      logic              irq_compare1;
      logic              irq_compare2;
   } timer_reply_type;

   logic clock;
   logic reset;

   tm16_req_if req_bus ();
   tm16_rsp_if rsp_bus ();

   timer16_period_compare_regs #(
      .COMPARE_CHANNELS (3)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // ---------------------------------------------------------------------------
   // Shadow timer: counter, period, compares and their buffers in one array
   // ---------------------------------------------------------------------------
   logic [TMR_W-1:0]   wide_reg [NUM_SLOTS];
   logic [BYTE_W-1:0]  temp_byte;
   logic [3:0]         ctrla_bits;        // bit0 enable, bits3:1 clock select
   logic [2:0]         wave_mode;
   logic [FLAG_W-1:0]  buf_valid;         // bit0 period, bit1+n compare n
   logic [FLAG_W-1:0]  irq_enable;        // bit0 overflow, bit1+n compare n
   logic [FLAG_W-1:0]  irq_flag;
   logic [PRESC_W-1:0] presc_count;

   timer_reply_type bus_reply_q [$];      // replies still owed by the block
   int errors;
   int cycle_count;

   bit sender_idle_on;
   bit receiver_idle_on;
   int hold_ask;                          // long hold-off asked of the receiver
   bit hold_taken;                        // receiver has picked the hold-off up
   int hold_left;
   int stall_left;

   function automatic void clear_timer_shadow();
      for (int i = 0; i < NUM_SLOTS; i++)
         wide_reg[i] = '0;
      wide_reg[SLOT_PER]    = 16'hFFFF;
      wide_reg[SLOT_PERBUF] = 16'hFFFF;
      temp_byte   = '0;
      ctrla_bits  = '0;
      wave_mode   = '0;
      buf_valid   = '0;
      irq_enable  = '0;
      irq_flag    = '0;
      presc_count = '0;
   endfunction

   // One prescaled tick: count up, flag matches, reload buffers on period match.
   // Compares are tested before any buffer is copied in.
   function automatic void count_step();
      logic [TMR_W-1:0] next_count;
      next_count = wide_reg[SLOT_CNT] + 16'd1;
      wide_reg[SLOT_CNT] = next_count;
      for (int ch = 0; ch < MAX_CH; ch++)
         if (next_count == wide_reg[SLOT_CMP + ch])
            irq_flag[ch + 1] = 1'b1;
      if (next_count == wide_reg[SLOT_PER]) begin
         wide_reg[SLOT_CNT] = '0;
         irq_flag[0] = 1'b1;
         if (buf_valid[0])
            wide_reg[SLOT_PER] = wide_reg[SLOT_PERBUF];
         for (int ch = 0; ch < MAX_CH; ch++)
            if (buf_valid[ch + 1])
               wide_reg[SLOT_CMP + ch] = wide_reg[SLOT_CMPBUF + ch];
         buf_valid = '0;
      end
   endfunction

   function automatic int wide_slot(input logic [OFS_W-1:0] ofs);
      logic [GRP_W-1:0] grp;
      grp = ofs[OFS_W-1:1];
      case (grp)
         GRP_CNT:    return SLOT_CNT;
         GRP_PER:    return SLOT_PER;
         GRP_PERBUF: return SLOT_PERBUF;
         GRP_CMP0, GRP_CMP0 + 5'd1, GRP_CMP0 + 5'd2:
            return SLOT_CMP + int'(grp - GRP_CMP0);
         GRP_CMPBUF0, GRP_CMPBUF0 + 5'd1, GRP_CMPBUF0 + 5'd2:
            return SLOT_CMPBUF + int'(grp - GRP_CMPBUF0);
         default:    return SLOT_NONE;
      endcase
   endfunction

   // Applies one accepted word to the shadow timer and returns the reply it owes.
   function automatic timer_reply_type apply_timer_word(input logic [CMD_W-1:0] cmd,
                                                        input logic [OFS_W-1:0] ofs,
                                                        input logic [BYTE_W-1:0] wdata);
      int slot;
      logic [BYTE_W-1:0] rd;
      logic [FLAG_W-1:0] live;
      logic [PRESC_W-1:0] div_mask;
      timer_reply_type reply;
      rd = '0;
      slot = wide_slot(ofs);
      case (cmd)
         CMD_TICK: begin
            if (!ctrla_bits[0]) begin
               presc_count = '0;
            end else begin
               div_mask = PRESC_W'(TICK_DIVISOR[ctrla_bits[3:1]] - 1);
               presc_count = presc_count + 10'd1;
               if ((presc_count & div_mask) == '0)
                  count_step();
            end
         end
         CMD_READ: begin
            case (ofs)
               OFS_CTRLA:    rd = {4'd0, ctrla_bits};
               OFS_CTRLB:    rd = {5'd0, wave_mode};
               OFS_CTRLFCLR,
               OFS_CTRLFSET: rd = {4'd0, buf_valid};
               OFS_INTCTRL:  rd = {1'b0, irq_enable[3:1], 3'd0, irq_enable[0]};
               OFS_INTFLAGS: rd = {1'b0, irq_flag[3:1], 3'd0, irq_flag[0]};
               OFS_TEMP:     rd = temp_byte;
               default: begin
                  if (slot != SLOT_NONE) begin
                     if (ofs[0]) begin
                        rd = temp_byte;
                     end else begin
                        temp_byte = wide_reg[slot][15:8];
                        rd = wide_reg[slot][7:0];
                     end
                  end
               end
            endcase
         end
         CMD_WRITE: begin
            case (ofs)
               OFS_CTRLA:    ctrla_bits = wdata[3:0];
               OFS_CTRLB:    wave_mode = wdata[2:0];
               OFS_CTRLFCLR: buf_valid = buf_valid & ~wdata[3:0];
               OFS_CTRLFSET: buf_valid = buf_valid | wdata[3:0];
               OFS_INTCTRL:  irq_enable = {wdata[6:4], wdata[0]};
               OFS_INTFLAGS: irq_flag = irq_flag & ~{wdata[6:4], wdata[0]};   // write 1 clears
               OFS_TEMP:     temp_byte = wdata;
               default: begin
                  if (slot != SLOT_NONE) begin
                     if (!ofs[0]) begin
                        temp_byte = wdata;
                     end else begin
                        wide_reg[slot] = {wdata, temp_byte};
                        if (slot >= SLOT_PERBUF)
                           buf_valid[slot - SLOT_PERBUF] = 1'b1;
                     end
                  end
               end
            endcase
         end
         default: ;   // spare command: nothing happens, rdata stays 0
      endcase
      live = irq_flag & irq_enable;
      reply.rdata        = rd;
      reply.irq_overflow = live[0];
      reply.irq_compare0 = live[1];
      reply.irq_compare1 = live[2];
      reply.irq_compare2 = live[3];
      return reply;
   endfunction

   // ---------------------------------------------------------------------------
   // Clock, cycle limit
   // ---------------------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Response side: ready driven on the falling edge. A long hold-off, when
   // asked for, is counted down here; otherwise random stall bursts when idling is on.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_ask > 0 && !hold_taken) begin
         hold_left = hold_ask;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic report_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
      $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
      errors++;
   endtask

   // Every accepted response word against the oldest reply still owed
   always @(posedge clock) begin
      timer_reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (bus_reply_q.size() == 0) begin
            $display("%0t: response word with none owed, expected none actual %02h",
                     $time, rsp_bus.rdata);
            errors++;
         end else begin
            want = bus_reply_q.pop_front();
            if (rsp_bus.rdata !== want.rdata)
               report_field("rdata", want.rdata, rsp_bus.rdata);
            if (rsp_bus.irq_overflow !== want.irq_overflow)
               report_field("irq_overflow", 8'(want.irq_overflow), 8'(rsp_bus.irq_overflow));
            if (rsp_bus.irq_compare0 !== want.irq_compare0)
               report_field("irq_compare0", 8'(want.irq_compare0), 8'(rsp_bus.irq_compare0));
            if (rsp_bus.irq_compare1 !== want.irq_compare1)
               report_field("irq_compare1", 8'(want.irq_compare1), 8'(rsp_bus.irq_compare1));
            if (rsp_bus.irq_compare2 !== want.irq_compare2)
               report_field("irq_compare2", 8'(want.irq_compare2), 8'(rsp_bus.irq_compare2));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side: entered and left on a falling edge. An optional idle burst
   // goes in front of the word; the word is held until the block takes it.
   // ---------------------------------------------------------------------------
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [OFS_W-1:0] ofs,
                            input logic [BYTE_W-1:0] wdata);
      int gap;
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.reg_offset <= ofs;
      req_bus.wdata      <= wdata;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      bus_reply_q.push_back(apply_timer_word(cmd, ofs, wdata));
      @(negedge clock);
   endtask

   // 16-bit access through TEMP: low byte first, then high byte
   task automatic write_wide(input logic [GRP_W-1:0] grp, input logic [TMR_W-1:0] value);
      send_word(CMD_WRITE, {grp, 1'b0}, value[7:0]);
      send_word(CMD_WRITE, {grp, 1'b1}, value[15:8]);
   endtask

   task automatic read_wide(input logic [GRP_W-1:0] grp);
      send_word(CMD_READ, {grp, 1'b0}, 8'($urandom));
      send_word(CMD_READ, {grp, 1'b1}, 8'($urandom));
   endtask

   task automatic wait_drain();
      while (bus_reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------------
   task automatic test_reset_state();
      read_wide(GRP_PER);                       // 0xFFFF out of reset, high byte via TEMP
      send_word(CMD_TICK, 6'h3F, 8'hFF);        // disabled: prescaler held, no count
   endtask

   task automatic test_unmapped_and_spare_cmd();
      send_word(CMD_WRITE, {GRP_SPARE, 1'b0}, 8'hFF);   // channel that is not there
      send_word(CMD_READ, {GRP_SPARE, 1'b0}, 8'h00);
      send_word(CMD_READ, 6'h05, 8'hFF);                // hole in the byte map
      send_word(2'd3, 6'h3F, 8'hFF);                    // spare command code
   endtask

   task automatic test_match_and_reload();
      send_word(CMD_WRITE, OFS_INTCTRL, 8'hFF);
      send_word(CMD_WRITE, OFS_CTRLA, 8'h01);           // enabled, divide by 1
      write_wide(GRP_CMP0, 16'd2);
      write_wide(GRP_PER, 16'd2);
      write_wide(GRP_CMPBUF0, 16'd5);                   // only compare 0 buffered
      // second tick: compare 0 and period match together, compare 0 reloads,
      // period keeps its value as its buffer is not valid
      send_word(CMD_TICK, 6'h00, 8'h00);
      send_word(CMD_TICK, 6'h00, 8'h00);
   endtask

   task automatic test_flag_and_valid_bits();
      send_word(CMD_READ, OFS_INTFLAGS, 8'h00);
      send_word(CMD_WRITE, OFS_INTFLAGS, 8'hFF);
      send_word(CMD_WRITE, OFS_CTRLFSET, 8'h0F);
      send_word(CMD_READ, OFS_CTRLFCLR, 8'h00);
      send_word(CMD_WRITE, OFS_CTRLFCLR, 8'h0F);
      send_word(CMD_WRITE, OFS_CTRLA, 8'h0F);           // slowest divisor
      send_word(CMD_TICK, 6'h00, 8'h00);
   endtask

   // ---------------------------------------------------------------------------
   // Random traffic: mostly ticks and well-formed 16-bit accesses with small
   // values so that matches and reloads keep happening, plus raw noise.
   // ---------------------------------------------------------------------------
   task automatic send_random_traffic(input int words);
      logic [GRP_W-1:0] wide_grp [10];
      logic [OFS_W-1:0] ctl_ofs [7];
      int sent;
      int pick;
      logic [TMR_W-1:0] value;
      logic [BYTE_W-1:0] byte_val;
      logic [OFS_W-1:0] ofs;
      wide_grp = '{GRP_CNT, GRP_PER, GRP_CMP0, GRP_CMP0 + 5'd1, GRP_CMP0 + 5'd2, GRP_PERBUF,
                   GRP_CMPBUF0, GRP_CMPBUF0 + 5'd1, GRP_CMPBUF0 + 5'd2, GRP_SPARE};
      ctl_ofs = '{OFS_CTRLA, OFS_CTRLB, OFS_CTRLFCLR, OFS_CTRLFSET, OFS_INTCTRL,
                  OFS_INTFLAGS, OFS_TEMP};
      sent = 0;
      while (sent < words) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_word(CMD_TICK, 6'($urandom), 8'($urandom));
            sent += 1;
         end else if (pick < 60) begin
            value = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            write_wide(wide_grp[$urandom_range(0, 9)], value);
            sent += 2;
         end else if (pick < 72) begin
            read_wide(wide_grp[$urandom_range(0, 9)]);
            sent += 2;
         end else if (pick < 84) begin
            ofs = ctl_ofs[$urandom_range(0, 6)];
            byte_val = 8'($urandom);
            // keep the timer mostly running on a fast divisor
            if (ofs == OFS_CTRLA && $urandom_range(0, 3) != 0)
               byte_val[3:0] = {3'($urandom_range(0, 2)), 1'b1};
            send_word(CMD_WRITE, ofs, byte_val);
            sent += 1;
         end else if (pick < 94) begin
            send_word(CMD_READ, ctl_ofs[$urandom_range(0, 6)], 8'($urandom));
            sent += 1;
         end else begin
            send_word(2'($urandom), 6'($urandom), 8'($urandom));
            sent += 1;
         end
      end
   endtask

   task automatic test_random_traffic();
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
      send_random_traffic(400);
   endtask

   // Receiver holds off for a long stretch while words keep coming: the
   // pipe fills and the block must stall its input without losing a word.
   task automatic test_backpressure();
      sender_idle_on = 1'b0;
      hold_ask = 80;
      send_random_traffic(60);
   endtask

   // Closing stretch with neither side idling
   task automatic test_steady_stream();
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      send_random_traffic(150);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_TICK;
      req_bus.reg_offset = '0;
      req_bus.wdata = '0;
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      hold_ask = 0;
      clear_timer_shadow();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_unmapped_and_spare_cmd();
      test_match_and_reload();
      test_flag_and_valid_bits();
      test_random_traffic();
      test_backpressure();
      test_steady_stream();

      req_bus.valid <= 1'b0;
      wait_drain();

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
